/* sv/murmur3_hash31_top_defines.svh */
// Assertion macros for the murmur3_hash31 block.
`ifndef MURMUR3_HASH31_TOP_DEFINES_SVH
`define MURMUR3_HASH31_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define M3H_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define M3H_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define M3H_ASSERT_SAME(label, ante, cons)
`define M3H_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/m3h31_pkg.sv */
// Shared widths and mixing constants for the murmur3_hash31 block.
package m3h31_pkg;
    localparam int WORD_W = 32;
    localparam int HASH_W = 31;
    localparam int CNT_W  = 3;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t MIX_C1   = 32'hcc9e2d51;
    localparam word_t MIX_C2   = 32'h1b873593;
    localparam word_t FOLD_ADD = 32'he6546b64;
    localparam word_t FIN_M1   = 32'h85ebca6b;
    localparam word_t FIN_M2   = 32'hc2b2ae35;

    localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;
endpackage

/* sv/murmur3_hash31_top.sv */
// Top level of the streaming MurmurHash3 x86_32 key hasher (31-bit result).
// Keys arrive as little-endian 32-bit words, one request per word; last_item
// closes the key and byte_count (0..4, values above 4 treated as 4) gives
// the bytes in that final word. Every key starts from the seed register,
// which is written through the cfg port; a write during a key applies to the
// next key. The block works on one word at a time: all multiplies go through
// a single registered 32x32 multiplier driven by a small sequencer. After
// acceptance a non-final word runs MIX1, MIX2, FOLD, ADD5 until s_ready returns;
// a final word adds FIN, FM1, FX1, FM2, FX2, a 1..3-byte one runs XORK in place
// of FOLD and ADD5, and an empty one starts at FIN. The result sits in an output
// register; the sequencer waits at its last step only if a previous result is untaken.
`include "murmur3_hash31_top_defines.svh"
module murmur3_hash31_top
    import m3h31_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_data_word,
    input  logic [CNT_W-1:0]  s_byte_count,
    input  logic              s_last_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HASH_W-1:0] m_hash_value
);
    typedef enum logic [3:0] {
        IDLE, MIX1, MIX2, FOLD, ADD5, XORK, FIN, FM1, FX1, FM2, FX2
    } state_t;

    state_t            state_reg, state_next;
    word_t             seed_reg, seed_next;
    word_t             hash_reg, hash_next;
    word_t             len_reg, len_next;
    word_t             key_reg, key_next;
    logic              in_msg_reg, in_msg_next;
    logic              last_reg, last_next;
    logic              full_reg, full_next;
    logic              m_valid_reg, m_valid_next;
    logic [HASH_W-1:0] m_hash_reg, m_hash_next;

    word_t             op_a, op_b, prod;
    word_t             key_mask, fin_x, out_h;
    logic [CNT_W-1:0]  cnt_sat;
    logic              accept, out_free;

    m3h31_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_sat  = !s_last_item ? CNT_FULL :
                      (s_byte_count > CNT_FULL) ? CNT_FULL : s_byte_count;
    assign fin_x    = hash_reg ^ len_reg;
    assign out_h    = prod ^ (prod >> 16);

    always_comb begin
        unique case (cnt_sat)
            3'd1:    key_mask = 32'h000000ff;
            3'd2:    key_mask = 32'h0000ffff;
            3'd3:    key_mask = 32'h00ffffff;
            default: key_mask = 32'hffffffff;
        endcase
    end

    // multiplier operand select
    always_comb begin
        unique case (state_reg)
            MIX1: begin
                op_a = key_reg;
                op_b = MIX_C1;
            end
            MIX2: begin
                op_a = {prod[16:0], prod[31:17]};
                op_b = MIX_C2;
            end
            FM1: begin
                op_a = hash_reg;
                op_b = FIN_M1;
            end
            // FX2 keeps the operands so the product holds during a stall
            FM2, FX2: begin
                op_a = hash_reg;
                op_b = FIN_M2;
            end
            default: begin
                op_a = hash_reg;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        seed_next    = cfg_valid ? cfg_data : seed_reg;
        hash_next    = hash_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        in_msg_next  = in_msg_reg;
        last_next    = last_reg;
        full_next    = full_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_hash_next  = m_hash_reg;
        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    hash_next   = in_msg_reg ? hash_reg : seed_reg;
                    len_next    = (in_msg_reg ? len_reg : '0) + word_t'(cnt_sat);
                    key_next    = s_data_word & key_mask;
                    in_msg_next = !s_last_item;
                    last_next   = s_last_item;
                    full_next   = (cnt_sat == CNT_FULL);
                    state_next  = (cnt_sat == '0) ? FIN : MIX1;
                end
            end
            MIX1: state_next = MIX2;
            MIX2: state_next = full_reg ? FOLD : XORK;
            FOLD: begin
                hash_next  = {hash_reg[18:0] ^ prod[18:0], hash_reg[31:19] ^ prod[31:19]};
                state_next = ADD5;
            end
            ADD5: begin
                hash_next  = (hash_reg << 2) + hash_reg + FOLD_ADD;
                state_next = last_reg ? FIN : IDLE;
            end
            XORK: begin
                hash_next  = hash_reg ^ prod;
                state_next = FIN;
            end
            FIN: begin
                hash_next  = fin_x ^ (fin_x >> 16);
                state_next = FM1;
            end
            FM1: state_next = FX1;
            FX1: begin
                hash_next  = prod ^ (prod >> 13);
                state_next = FM2;
            end
            FM2: state_next = FX2;
            FX2: begin
                // product stays valid while we wait for the output register
                if (out_free) begin
                    hash_next    = out_h;
                    m_valid_next = 1'b1;
                    m_hash_next  = out_h[HASH_W-1:0];
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            seed_reg    <= '0;
            hash_reg    <= '0;
            len_reg     <= '0;
            in_msg_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seed_reg    <= seed_next;
            hash_reg    <= hash_next;
            len_reg     <= len_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        last_reg   <= last_next;
        full_reg   <= full_next;
        m_hash_reg <= m_hash_next;
    end

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == IDLE);
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    `M3H_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `M3H_ASSERT_NEXT(a_result_only_from_fx2, (state_reg != FX2) && !m_valid, !m_valid)
    `M3H_ASSERT_NEXT(a_fx2_holds_on_stall, (state_reg == FX2) && m_valid && !m_ready,
                     (state_reg == FX2) && $stable(m_hash_value))
endmodule

/* sv/m3h31_mul.sv */
// Shared 32x32 multiplier, low 32 bits of the product, registered.
module m3h31_mul
    import m3h31_pkg::*;
(
    input  logic  aclk,
    input  word_t op_a,
    input  word_t op_b,
    output word_t prod
);
    word_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= word_t'(op_a * op_b);
    end

    assign prod = prod_reg;
endmodule

/* bench/murmur3_hash31_top_test.sv */
// Self-checking testbench for the streaming 31-bit MurmurHash3 key hasher.
module murmur3_hash31_top_test;
    import m3h31_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [CNT_W-1:0]  count_t;

    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    word_t             cfg_data     = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    word_t             s_data_word  = '0;
    count_t            s_byte_count = '0;
    logic              s_last_item  = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    hash_t             m_hash_value;

    murmur3_hash31_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_item  (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // hash state as the block should hold it
    word_t seed_reg = '0;
    word_t acc_hash = '0;
    word_t key_len  = '0;
    logic  key_open = 1'b0;

    hash_t pending_hashes[$];
    hash_t expected_hash;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int items_sent = 0;
    int keys_checked = 0;

    function automatic word_t rol(input word_t x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic word_t mix_word(input word_t k);
        k = k * MIX_C1;
        k = rol(k, 15);
        return k * MIX_C2;
    endfunction

    function automatic word_t fold_word(input word_t h, input word_t k);
        h = h ^ mix_word(k);
        h = rol(h, 13);
        return h * 32'd5 + FOLD_ADD;
    endfunction

    function automatic word_t avalanche(input word_t h);
        h = h ^ (h >> 16);
        h = h * FIN_M1;
        h = h ^ (h >> 13);
        h = h * FIN_M2;
        return h ^ (h >> 16);
    endfunction

    task automatic predict_hash(input word_t word, input count_t cnt, input logic last);
        word_t h;
        word_t mask;
        int    n;
        if (!key_open) begin
            acc_hash = seed_reg;
            key_len  = '0;
        end
        if (!last) begin
            // byte count is ignored until the closing request
            acc_hash = fold_word(acc_hash, word);
            key_len  = key_len + 32'd4;
            key_open = 1'b1;
        end else begin
            n = (cnt > CNT_FULL) ? int'(CNT_FULL) : int'(cnt);
            h = acc_hash;
            if (n == int'(CNT_FULL)) begin
                h = fold_word(h, word);
            end else if (n != 0) begin
                mask = (32'h1 << (8 * n)) - 32'h1;
                h = h ^ mix_word(word & mask);
            end
            key_len = key_len + word_t'(n);
            h = avalanche(h ^ key_len);
            pending_hashes.push_back(h[HASH_W-1:0]);
            acc_hash = h;
            key_open = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash, expected none, got %h", $time, m_hash_value);
                errors++;
            end else begin
                expected_hash = pending_hashes.pop_front();
                if (m_hash_value !== expected_hash) begin
                    $display("%0t: hash_value mismatch, expected %h, got %h",
                             $time, expected_hash, m_hash_value);
                    errors++;
                end
                keys_checked++;
            end
        end
    end

    task automatic send_item(input word_t word, input count_t cnt, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_word  <= word;
        s_byte_count <= cnt;
        s_last_item  <= last;
        do @(posedge aclk); while (!s_ready);
        predict_hash(word, cnt, last);
        items_sent++;
    endtask

    // wait for every expected hash, then let any in-flight word finish
    task automatic drain;
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input word_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        seed_reg = value;
    endtask

    task automatic test_empty_key;
        send_item($urandom(), 3'd0, 1'b1);
        drain();
    endtask

    task automatic test_final_counts;
        send_item(32'hffffffff, 3'd4, 1'b1);
        send_item(32'h00000000, 3'd4, 1'b1);
        // garbage above the valid bytes must not matter
        send_item(32'hdeadbeef, 3'd1, 1'b1);
        send_item(32'hdeadbeef, 3'd2, 1'b1);
        send_item(32'hffffffff, 3'd3, 1'b1);
        // counts 5..7 saturate to a full word
        send_item(32'h01234567, 3'd5, 1'b1);
        send_item(32'h89abcdef, 3'd6, 1'b1);
        send_item(32'hffffffff, 3'd7, 1'b1);
        drain();
    endtask

    task automatic test_ignored_count;
        send_item(32'h00000000, 3'd0, 1'b0);
        send_item(32'hffffffff, 3'd7, 1'b0);
        send_item(32'ha5a5a5a5, 3'd0, 1'b1);
        drain();
    endtask

    task automatic test_seed_mid_key;
        send_item($urandom(), 3'd1, 1'b0);
        send_item($urandom(), 3'd4, 1'b0);
        drain();
        // new seed only applies from the next key on
        write_seed(32'hffffffff);
        send_item($urandom(), 3'd2, 1'b1);
        send_item($urandom(), 3'd0, 1'b1);
        drain();
    endtask

    task automatic test_random_keys(input word_t seed, input int idle_pct,
                                    input int stall_pct, input int n_items);
        int target;
        int n_words;
        target = items_sent + n_items;
        drain();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_seed(seed);
        while (items_sent < target) begin
            n_words = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(0, 4);
            repeat (n_words) send_item($urandom(), count_t'($urandom_range(0, 7)), 1'b0);
            if ($urandom_range(0, 9) < 8) begin
                send_item($urandom(), count_t'($urandom_range(0, 4)), 1'b1);
            end else begin
                send_item($urandom(), count_t'($urandom_range(5, 7)), 1'b1);
            end
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_key();
        test_final_counts();
        test_ignored_count();
        test_seed_mid_key();

        test_random_keys(32'h00000000, 0, 0, 125);
        test_random_keys($urandom(), 63, 0, 125);
        test_random_keys(32'hffffffff, 0, 63, 125);
        test_random_keys($urandom(), 38, 38, 125);

        drain();
        if (pending_hashes.size() != 0) begin
            $display("%0t: %0d expected hashes never arrived, first %h",
                     $time, pending_hashes.size(), pending_hashes[0]);
            errors++;
        end
        $display("Sent %0d requests and checked %0d key hashes over four seeds,", items_sent,
                 keys_checked);
        $display("with and without sender gaps and receiver stalls; %0d errors.", errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
